/* sv/csml_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// csml_pkg
// Shared constants and types for the cross-stencil mean/Laplacian core.
// ============================================================================
package csml_pkg;

   // Line store depth and the widths that follow from it
   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int CNT_W     = $clog2(MAX_WIDTH + 1);

   // Field and register widths
   localparam int PIX_W     = 8;
   localparam int COL_W     = 10;
   localparam int ROW_W     = 12;
   localparam int MODE_W    = 2;
   localparam int WIDTH_W   = 11;
   localparam int HEIGHT_W  = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;

   localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

   // Queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   // Filter modes
   localparam logic [MODE_W-1:0] MODE_MEAN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LAP  = 2'd1;

   // Reset values
   localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

   // Result slot order inside one queued entry
   localparam int SLOT_UP_MID   = 0;  // (c-1, r-1)
   localparam int SLOT_UP_END   = 1;  // (c,   r-1)
   localparam int SLOT_LAST_MID = 2;  // (c-1, r)
   localparam int SLOT_LAST_END = 3;  // (c,   r)

   // One queued entry: window snapshot plus the results it owes
   typedef struct packed {
      logic [8:0][PIX_W-1:0] win;
      logic [ADDR_W-1:0]     col;
      logic [ROW_W-1:0]      row;
      logic [3:0]            mask;
   } entry_type;

   typedef struct packed {
      logic      vld;
      entry_type ent;
   } push_type;

   typedef struct packed {
      logic      vld;
      entry_type ent;
   } head_type;

endpackage

/* sv/cross_stencil_mean_laplacian_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// cross_stencil_mean_laplacian_core
// Five-point cross stencil filter (mean, offset Laplacian or pass) over a
// raster pixel stream with edge replication.
// ============================================================================
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_stall, req_pixel_in      | in
//  rsp     | rsp_valid, rsp_stall, rsp_pixel_out,    | out
//          | rsp_out_col, rsp_out_row, rsp_run_last  |
//  csr     | csr_wr_en, csr_index, csr_wdata         | in
//
//  One request per cycle is taken while req_stall is low; it reads the line
//  store at accept and, if it owes a result, pushes its window snapshot to a
//  4-entry queue in the following cycle. The back end emits one result per
//  cycle while rsp_stall is low, so a last-row row-end request with four
//  results holds the back until all are out; the queue absorbs this.
//  reset is synchronous; no clearing pass, the line store needs none.
//  req_stall rises only when the queue and stage 1 leave no room for another.
module cross_stencil_mean_laplacian_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [csml_pkg::PIX_W-1:0]         req_pixel_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [csml_pkg::PIX_W-1:0]         rsp_pixel_out,
   output logic [csml_pkg::COL_W-1:0]         rsp_out_col,
   output logic [csml_pkg::ROW_W-1:0]         rsp_out_row,
   output logic                               rsp_run_last,
   input  logic                               csr_wr_en,
   input  logic [csml_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [csml_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   logic [csml_pkg::MODE_W-1:0]   mode_ff;
   logic [csml_pkg::WIDTH_W-1:0]  width_ff;
   logic [csml_pkg::HEIGHT_W-1:0] height_ff;
   logic [csml_pkg::CNT_W-1:0]    eff_w;
   logic [csml_pkg::HEIGHT_W-1:0] eff_h;
   logic                          can_accept, accept, pop;
   logic [csml_pkg::QCNT_W-1:0]   q_count;
   csml_pkg::push_type            push;
   csml_pkg::head_type            head;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= csml_pkg::MODE_MEAN;
         width_ff  <= csml_pkg::WIDTH_RST;
         height_ff <= csml_pkg::HEIGHT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            csml_pkg::CSR_MODE:   mode_ff   <= csr_wdata[csml_pkg::MODE_W-1:0];
            csml_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[csml_pkg::WIDTH_W-1:0];
            csml_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Active frame size: zero means one, saturate at the limits
   always_comb begin
      if (width_ff == '0)
         eff_w = csml_pkg::CNT_W'(1);
      else if (32'(width_ff) > csml_pkg::MAX_WIDTH)
         eff_w = csml_pkg::CNT_W'(csml_pkg::MAX_WIDTH);
      else
         eff_w = csml_pkg::CNT_W'(width_ff);
      if (height_ff == '0)
         eff_h = csml_pkg::HEIGHT_W'(1);
      else if (height_ff > csml_pkg::HEIGHT_LIMIT)
         eff_h = csml_pkg::HEIGHT_LIMIT;
      else
         eff_h = height_ff;
   end

   assign req_stall = !can_accept;
   assign accept    = req_valid && can_accept;

   csml_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .pixel      (req_pixel_in),
      .eff_w      (eff_w),
      .eff_h      (eff_h),
      .q_count    (q_count),
      .can_accept (can_accept),
      .push       (push)
   );

   csml_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (q_count)
   );

   csml_back u_back (
      .clock         (clock),
      .reset         (reset),
      .mode          (mode_ff),
      .head          (head),
      .pop           (pop),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

/* sv/csml_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// csml_front
// Position counters, two-row line store and 3x3 window. Each request moves
// through one read stage, then queues a window snapshot if it owes results.
// ============================================================================
module csml_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [csml_pkg::PIX_W-1:0]          pixel,
   input  logic [csml_pkg::CNT_W-1:0]          eff_w,
   input  logic [csml_pkg::HEIGHT_W-1:0]       eff_h,
   input  logic [csml_pkg::QCNT_W-1:0]         q_count,
   output logic                                can_accept,
   output csml_pkg::push_type                  push
);

   logic [csml_pkg::CNT_W-1:0]   col_ff, col_in;
   logic [csml_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [csml_pkg::CNT_W-1:0]   c;
   logic [csml_pkg::HEIGHT_W-1:0] r_step, r;
   logic [csml_pkg::HEIGHT_W-1:0] r_next;
   logic                          row_end, last_row;

   // Stage 1 registers
   logic                          s1_vld_ff;
   logic [csml_pkg::ADDR_W-1:0]   s1_col_ff;
   logic [csml_pkg::ROW_W-1:0]    s1_row_ff;
   logic [csml_pkg::PIX_W-1:0]    s1_pix_ff;
   logic [3:0]                    s1_mask_ff, mask_in;
   logic [2*csml_pkg::PIX_W-1:0]  rd_ff;
   logic                          byp_ff;
   logic [2*csml_pkg::PIX_W-1:0]  byp_data_ff;
   logic [2*csml_pkg::PIX_W-1:0]  s1_rd;
   logic [csml_pkg::PIX_W-1:0]    s1_m, s1_t;

   logic [8:0][csml_pkg::PIX_W-1:0] win_ff, win_in;

   // Line store: upper byte is the row above, lower byte the row two above
   logic [2*csml_pkg::PIX_W-1:0] line_mem [csml_pkg::MAX_WIDTH];

   // Credit check: room for the item in stage 1 and this one
   assign can_accept = (32'(q_count) + 32'(s1_vld_ff)) < csml_pkg::QDEPTH;

   // Current position after wrap against the active frame size
   always_comb begin
      c      = (col_ff >= eff_w) ? '0 : col_ff;
      r_step = (col_ff >= eff_w) ? csml_pkg::HEIGHT_W'(row_ff) + 1'b1
                                 : csml_pkg::HEIGHT_W'(row_ff);
      r        = (r_step >= eff_h) ? '0 : r_step;
      row_end  = (c == eff_w - 1'b1);
      last_row = (r == eff_h - 1'b1);
      r_next   = r + 1'b1;
      if (row_end) begin
         col_in = '0;
         row_in = (r_next >= eff_h) ? '0 : csml_pkg::ROW_W'(r_next);
      end else begin
         col_in = c + 1'b1;
         row_in = csml_pkg::ROW_W'(r);
      end
      mask_in = '0;
      mask_in[csml_pkg::SLOT_UP_MID]   = (r != '0) && (c != '0);
      mask_in[csml_pkg::SLOT_UP_END]   = (r != '0) && row_end;
      mask_in[csml_pkg::SLOT_LAST_MID] = last_row && (c != '0);
      mask_in[csml_pkg::SLOT_LAST_END] = last_row && row_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // Read at accept; stage 1 writes back in the following cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff       <= line_mem[c[csml_pkg::ADDR_W-1:0]];
         s1_col_ff   <= c[csml_pkg::ADDR_W-1:0];
         s1_row_ff   <= csml_pkg::ROW_W'(r);
         s1_pix_ff   <= pixel;
         s1_mask_ff  <= mask_in;
         byp_ff      <= s1_vld_ff && (s1_col_ff == c[csml_pkg::ADDR_W-1:0]);
         byp_data_ff <= {s1_pix_ff, s1_m};
      end
      if (s1_vld_ff) begin
         line_mem[s1_col_ff] <= {s1_pix_ff, s1_m};
      end
   end

   // Forward a write that lands at the same edge as the read
   assign s1_rd = byp_ff ? byp_data_ff : rd_ff;
   assign s1_m  = s1_rd[2*csml_pkg::PIX_W-1:csml_pkg::PIX_W];
   assign s1_t  = s1_rd[csml_pkg::PIX_W-1:0];

   // Window shift: columns move left, new column enters on the right
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         win_in[i] = win_ff[i+3];
      end
      win_in[6] = s1_t;
      win_in[7] = s1_m;
      win_in[8] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_vld_ff) begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      push.vld      = s1_vld_ff && (s1_mask_ff != '0);
      push.ent.win  = win_in;
      push.ent.col  = s1_col_ff;
      push.ent.row  = s1_row_ff;
      push.ent.mask = s1_mask_ff;
   end

endmodule

/* sv/csml_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// csml_queue
// Short FIFO of window snapshots between the front and the back.
// ============================================================================
module csml_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  csml_pkg::push_type            push,
   input  logic                          pop,
   output csml_pkg::head_type            head,
   output logic [csml_pkg::QCNT_W-1:0]   count
);

   csml_pkg::entry_type             slot_ff [csml_pkg::QDEPTH];
   logic [csml_pkg::QPTR_W-1:0]     wr_ff, rd_ff;
   logic [csml_pkg::QCNT_W-1:0]     cnt_ff;

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push.vld) wr_ff <= wr_ff + 1'b1;
         if (pop)      rd_ff <= rd_ff + 1'b1;
         if (push.vld && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (!push.vld && pop) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push.vld) begin
         slot_ff[wr_ff] <= push.ent;
      end
   end

   assign head.vld = (cnt_ff != '0);
   assign head.ent = slot_ff[rd_ff];
   assign count    = cnt_ff;

endmodule

/* sv/csml_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// csml_back
// Walks the owed results of the head entry, one per cycle unless stalled,
// applies the filter and holds each result in the output register.
// ============================================================================
module csml_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [csml_pkg::MODE_W-1:0]    mode,
   input  csml_pkg::head_type             head,
   output logic                           pop,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [csml_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic [csml_pkg::COL_W-1:0]     rsp_out_col,
   output logic [csml_pkg::ROW_W-1:0]     rsp_out_row,
   output logic                           rsp_run_last
);

   logic [3:0]                   done_ff, rem, sel;
   logic                         fire, is_last;
   logic                         col2, lvl1, x_zero, y_zero;
   logic [3:0]                   base;
   logic [csml_pkg::PIX_W-1:0]   pc, pl, pr, pu, pd;
   logic [csml_pkg::ADDR_W-1:0]  x;
   logic [csml_pkg::ROW_W-1:0]   y;
   logic [9:0]                   sum4;
   logic [10:0]                  sum5;
   logic [24:0]                  prod;
   logic signed [11:0]           lap;
   logic [csml_pkg::PIX_W-1:0]   val;

   logic                         vld_ff;
   logic [csml_pkg::PIX_W-1:0]   pix_ff;
   logic [csml_pkg::COL_W-1:0]   col_ff;
   logic [csml_pkg::ROW_W-1:0]   row_ff;
   logic                         last_ff;

   // Pick the lowest result still owed by the head entry
   always_comb begin
      rem     = head.ent.mask & ~done_ff;
      sel     = rem & (~rem + 1'b1);
      is_last = ((rem & ~sel) == '0);
      fire    = head.vld && (!vld_ff || !rsp_stall);
      pop     = fire && is_last;
   end

   // Gather the stencil for the chosen slot
   always_comb begin
      col2   = sel[csml_pkg::SLOT_UP_END] || sel[csml_pkg::SLOT_LAST_END];
      lvl1   = sel[csml_pkg::SLOT_LAST_MID] || sel[csml_pkg::SLOT_LAST_END];
      base   = (col2 ? 4'd6 : 4'd3) + (lvl1 ? 4'd1 : 4'd0);
      x      = col2 ? head.ent.col : head.ent.col - 1'b1;
      y      = lvl1 ? head.ent.row : head.ent.row - 1'b1;
      x_zero = (x == '0);
      y_zero = (y == '0);
      pc     = head.ent.win[base + 4'd1];
      pu     = y_zero ? pc : head.ent.win[base];
      pd     = lvl1 ? pc : head.ent.win[base + 4'd2];
      pl     = x_zero ? pc : head.ent.win[base - 4'd2];
      pr     = col2 ? pc : head.ent.win[base + 4'd4];
   end

   // Filter: divide by 5 through reciprocal 3277/2^14, exact below 1280
   always_comb begin
      sum4 = 10'(pl) + 10'(pr) + 10'(pu) + 10'(pd);
      sum5 = 11'(sum4) + 11'(pc);
      prod = 25'(sum5) * 25'd3277;
      lap  = 12'sd128 + $signed({2'b00, sum4}) - $signed({2'b00, pc, 2'b00});
      case (mode)
         csml_pkg::MODE_MEAN: val = prod[21:14];
         csml_pkg::MODE_LAP: begin
            if (lap < 0)           val = '0;
            else if (lap > 12'sd255) val = 8'd255;
            else                   val = lap[7:0];
         end
         default: val = pc;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         done_ff <= '0;
      end else begin
         if (fire) begin
            vld_ff  <= 1'b1;
            done_ff <= is_last ? '0 : (done_ff | sel);
         end else if (!rsp_stall) begin
            vld_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pix_ff  <= val;
         col_ff  <= csml_pkg::COL_W'(x);
         row_ff  <= y;
         last_ff <= is_last;
      end
   end

   assign rsp_valid     = vld_ff;
   assign rsp_pixel_out = pix_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_run_last  = last_ff;

endmodule

/* sv/csml_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// csml_checker
// Port-level checks for the cross-stencil core, bound to the top level.
// ============================================================================
module csml_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [csml_pkg::PIX_W-1:0]     rsp_pixel_out,
   input logic [csml_pkg::COL_W-1:0]     rsp_out_col,
   input logic [csml_pkg::ROW_W-1:0]     rsp_out_row,
   input logic                           rsp_run_last
);

   // Reset empties the output register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A run of results from one request has no gaps
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_run_last) |=> rsp_valid)
      else $error("gap inside a result run");

   // Stalled result stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("rsp_valid dropped under stall");

   // Stalled result payload holds
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_pixel_out) && $stable(rsp_out_col)
                                    && $stable(rsp_out_row) && $stable(rsp_run_last)))
      else $error("rsp payload changed under stall");

endmodule

bind cross_stencil_mean_laplacian_core csml_checker u_csml_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pixel_out (rsp_pixel_out),
   .rsp_out_col   (rsp_out_col),
   .rsp_out_row   (rsp_out_row),
   .rsp_run_last  (rsp_run_last)
);
